FILE: rtl/core/ffsa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffsa_pkg
// Shared types, codes and defaults of the first-fit slot allocator.
// ----------------------------------------------------------------------------
package ffsa_pkg;

    localparam int SLOTS_DEF      = 1024;
    localparam int VALUE_BITS_DEF = 32;

    // stream widths
    localparam int IN_TDATA_W  = 32;
    localparam int IN_TUSER_W  = 2;
    localparam int SLOT_OUT_W  = 10;
    localparam int UNPL_W      = 32;
    localparam int OUT_TDATA_W = 48;
    localparam int OUT_TUSER_W = 3;

    // request kinds; the high bit alone selects a clear
    localparam logic [IN_TUSER_W-1:0] KIND_LOAD  = 2'd0;
    localparam logic [IN_TUSER_W-1:0] KIND_PLACE = 2'd1;
    localparam int                    KIND_CLEAR_BIT = 1;

    typedef enum logic [OUT_TUSER_W-1:0] {
        ST_LOADED     = 3'd0,
        ST_PLACED     = 3'd1,
        ST_NOT_PLACED = 3'd2,
        ST_FULL       = 3'd3,
        ST_CLEARED    = 3'd4
    } status_code_t;

    typedef enum logic [2:0] {
        OP_NOP      = 3'd0,
        OP_ACCEPT   = 3'd1,
        OP_ROOT     = 3'd2,
        OP_DOWN     = 3'd3,
        OP_SET_LEAF = 3'd4,
        OP_UP_READ  = 3'd5,
        OP_UP_WRITE = 3'd6,
        OP_RESP     = 3'd7
    } dp_op_t;

    typedef struct packed {
        dp_op_t       op;
        logic         set_code;
        status_code_t code;
    } dp_cmd_t;

    typedef struct packed {
        logic kind_clear;
        logic kind_load;
        logic table_full;
        logic fit;
        logic leaf_now;
        logic leaf_next;
        logic at_root;
        logic out_free;
    } dp_status_t;

endpackage

FILE: rtl/core/ffsa_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffsa_ctrl
// Sequencer of the allocator: walks the tree down for a placement and back
// up for every leaf update, one datapath operation per cycle.
// ----------------------------------------------------------------------------
module ffsa_ctrl
    import ffsa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  dp_status_t st,
    output dp_cmd_t    cmd
);

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_ROOT     = 7'b0000010,
        S_DOWN     = 7'b0000100,
        S_SET_LEAF = 7'b0001000,
        S_UP_READ  = 7'b0010000,
        S_UP_WRITE = 7'b0100000,
        S_RESP     = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd.op       = OP_NOP;
        cmd.set_code = 1'b0;
        cmd.code     = ST_LOADED;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.op       = OP_ACCEPT;
                    cmd.set_code = 1'b1;
                    if (st.kind_clear)
                    begin
                        cmd.code   = ST_CLEARED;
                        state_next = S_RESP;
                    end
                    else if (st.kind_load)
                    begin
                        if (st.table_full)
                        begin
                            cmd.code   = ST_FULL;
                            state_next = S_RESP;
                        end
                        else
                        begin
                            cmd.code   = ST_LOADED;
                            state_next = S_UP_READ;
                        end
                    end
                    else
                    begin
                        cmd.set_code = 1'b0;
                        state_next   = S_ROOT;
                    end
                end
            end
            S_ROOT:
            begin
                cmd.op = OP_ROOT;
                if (!st.fit)
                begin
                    cmd.set_code = 1'b1;
                    cmd.code     = ST_NOT_PLACED;
                    state_next   = S_RESP;
                end
                else if (st.leaf_now)
                begin
                    state_next = S_SET_LEAF;
                end
                else
                begin
                    state_next = S_DOWN;
                end
            end
            S_DOWN:
            begin
                cmd.op = OP_DOWN;
                if (st.leaf_next)
                begin
                    state_next = S_SET_LEAF;
                end
            end
            S_SET_LEAF:
            begin
                cmd.op       = OP_SET_LEAF;
                cmd.set_code = 1'b1;
                cmd.code     = ST_PLACED;
                state_next   = S_UP_READ;
            end
            S_UP_READ:
            begin
                cmd.op     = OP_UP_READ;
                state_next = st.at_root ? S_RESP : S_UP_WRITE;
            end
            S_UP_WRITE:
            begin
                cmd.op     = OP_UP_WRITE;
                state_next = S_UP_READ;
            end
            S_RESP:
            begin
                cmd.op = OP_RESP;
                if (st.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign s_tready = (state_reg == S_IDLE);

endmodule

FILE: rtl/core/ffsa_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffsa_datapath
// Max tree in a one-port memory, walk registers, counters and the result
// register. Nodes whose range starts at or beyond the loaded count read as
// minus one, so a clear only resets the counters.
// ----------------------------------------------------------------------------
module ffsa_datapath
    import ffsa_pkg::*;
#(
    parameter int SLOTS      = SLOTS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    input  logic [IN_TUSER_W-1:0]  s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic [OUT_TUSER_W-1:0] m_tuser,
    input  dp_cmd_t                cmd,
    output dp_status_t             st
);

    localparam int LOG    = $clog2(SLOTS);
    localparam int P      = 1 << LOG;
    localparam int NODE_W = LOG + 1;
    localparam int DEPTH  = 2 * P;
    localparam int SLOT_W = (LOG > 0) ? LOG : 1;
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int VW     = (VALUE_BITS < IN_TDATA_W) ? VALUE_BITS : IN_TDATA_W;
    localparam int NV_W   = VW + 1;

    localparam logic signed [NV_W-1:0] NEG_ONE = {NV_W{1'b1}};

    logic signed [NV_W-1:0] mem [DEPTH];

    logic [NODE_W-1:0]      node_reg, node_next;
    logic [NODE_W-1:0]      span_reg, span_next;
    logic [SLOT_W-1:0]      lo_reg, lo_next;
    logic signed [NV_W-1:0] cur_reg, cur_next;
    logic [VW-1:0]          want_reg, want_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [UNPL_W-1:0]      unpl_reg, unpl_next;
    status_code_t           code_reg, code_next;
    logic signed [NV_W-1:0] rdata_reg;
    logic                   rd_ok_reg, rd_ok_next;
    logic                   out_valid_reg, out_valid_next;
    status_code_t           out_code_reg, out_code_next;
    logic [SLOT_OUT_W-1:0]  out_slot_reg, out_slot_next;
    logic [UNPL_W-1:0]      out_unpl_reg, out_unpl_next;

    logic                   mem_we;
    logic                   mem_re;
    logic [NODE_W-1:0]      mem_addr;
    logic signed [NV_W-1:0] mem_wdata;
    logic [SLOT_W-1:0]      rd_start;

    logic [VW-1:0]          value_in;
    logic signed [NV_W-1:0] eff;
    logic signed [NV_W-1:0] want_s;
    logic signed [NV_W-1:0] parent;
    logic                   fit;
    logic                   table_full;
    logic                   go_right;
    logic [NODE_W-1:0]      half;
    logic [NODE_W-1:0]      down_node;
    logic [SLOT_W-1:0]      down_lo;
    logic [NODE_W-1:0]      leaf_node;
    logic [NODE_W-1:0]      lo_ext;
    logic [NODE_W-1:0]      sib_start;
    logic [SLOT_W+SLOT_OUT_W-1:0] slot_wide;
    logic                   out_free;

    assign value_in   = s_tdata[VW-1:0];
    assign eff        = rd_ok_reg ? rdata_reg : NEG_ONE;
    assign want_s     = signed'({1'b0, want_reg});
    assign fit        = (eff >= want_s);
    assign parent     = (cur_reg > eff) ? cur_reg : eff;
    assign table_full = (count_reg == CNT_W'(SLOTS));
    assign go_right   = !fit;
    assign half       = span_reg >> 1;
    assign down_node  = NODE_W'({node_reg, go_right});
    assign down_lo    = go_right ? (lo_reg + SLOT_W'(half)) : lo_reg;
    assign leaf_node  = NODE_W'(P) + NODE_W'(count_reg);
    assign lo_ext     = NODE_W'(lo_reg);
    // sibling range start: this node's start with the span bit flipped
    assign sib_start  = (lo_ext & ~(span_reg - NODE_W'(1))) ^ span_reg;
    assign slot_wide  = {{SLOT_OUT_W{1'b0}}, lo_reg};
    assign out_free   = !out_valid_reg || m_tready;

    assign st.kind_clear = s_tuser[KIND_CLEAR_BIT];
    assign st.kind_load  = (s_tuser == KIND_LOAD);
    assign st.table_full = table_full;
    assign st.fit        = fit;
    assign st.leaf_now   = (span_reg == NODE_W'(1));
    assign st.leaf_next  = (half == NODE_W'(1));
    assign st.at_root    = (node_reg == NODE_W'(1));
    assign st.out_free   = out_free;

    always_comb
    begin
        node_next      = node_reg;
        span_next      = span_reg;
        lo_next        = lo_reg;
        cur_next       = cur_reg;
        want_next      = want_reg;
        count_next     = count_reg;
        unpl_next      = unpl_reg;
        code_next      = cmd.set_code ? cmd.code : code_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_code_next  = out_code_reg;
        out_slot_next  = out_slot_reg;
        out_unpl_next  = out_unpl_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_addr       = '0;
        mem_wdata      = cur_reg;
        rd_start       = '0;
        case (cmd.op)
            OP_ACCEPT:
            begin
                if (s_tuser[KIND_CLEAR_BIT])
                begin
                    count_next = '0;
                    unpl_next  = '0;
                end
                else if (s_tuser == KIND_LOAD)
                begin
                    if (!table_full)
                    begin
                        mem_we     = 1'b1;
                        mem_addr   = leaf_node;
                        mem_wdata  = signed'({1'b0, value_in});
                        cur_next   = signed'({1'b0, value_in});
                        node_next  = leaf_node;
                        span_next  = NODE_W'(1);
                        lo_next    = SLOT_W'(count_reg);
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                else
                begin
                    want_next = value_in;
                    node_next = NODE_W'(1);
                    span_next = NODE_W'(P);
                    lo_next   = '0;
                    mem_re    = 1'b1;
                    mem_addr  = NODE_W'(1);
                end
            end
            OP_ROOT:
            begin
                if (!fit)
                begin
                    if (unpl_reg != {UNPL_W{1'b1}})
                    begin
                        unpl_next = unpl_reg + UNPL_W'(1);
                    end
                end
                else if (span_reg != NODE_W'(1))
                begin
                    mem_re   = 1'b1;
                    mem_addr = NODE_W'({node_reg, 1'b0});
                    rd_start = lo_reg;
                end
            end
            OP_DOWN:
            begin
                // left child fits: go left, else the right one must
                node_next = down_node;
                lo_next   = down_lo;
                span_next = half;
                if (half != NODE_W'(1))
                begin
                    mem_re   = 1'b1;
                    mem_addr = NODE_W'({down_node, 1'b0});
                    rd_start = down_lo;
                end
            end
            OP_SET_LEAF:
            begin
                mem_we    = 1'b1;
                mem_addr  = node_reg;
                mem_wdata = NEG_ONE;
                cur_next  = NEG_ONE;
            end
            OP_UP_READ:
            begin
                if (node_reg != NODE_W'(1))
                begin
                    mem_re   = 1'b1;
                    mem_addr = node_reg ^ NODE_W'(1);
                    rd_start = SLOT_W'(sib_start);
                end
            end
            OP_UP_WRITE:
            begin
                mem_we    = 1'b1;
                mem_addr  = node_reg >> 1;
                mem_wdata = parent;
                cur_next  = parent;
                node_next = node_reg >> 1;
                span_next = span_reg << 1;
            end
            OP_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_code_next  = code_reg;
                    out_unpl_next  = unpl_reg;
                    if (code_reg == ST_LOADED || code_reg == ST_PLACED)
                    begin
                        out_slot_next = slot_wide[SLOT_OUT_W-1:0];
                    end
                    else
                    begin
                        out_slot_next = '0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    assign rd_ok_next = ({{CNT_W{1'b0}}, rd_start} < {{SLOT_W{1'b0}}, count_reg});

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            unpl_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            unpl_reg      <= unpl_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg     <= node_next;
        span_reg     <= span_next;
        lo_reg       <= lo_next;
        cur_reg      <= cur_next;
        want_reg     <= want_next;
        code_reg     <= code_next;
        out_code_reg <= out_code_next;
        out_slot_reg <= out_slot_next;
        out_unpl_reg <= out_unpl_next;
        if (mem_re)
        begin
            rd_ok_reg <= rd_ok_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_code_reg;
    assign m_tdata  = {{(OUT_TDATA_W - SLOT_OUT_W - UNPL_W){1'b0}}, out_unpl_reg, out_slot_reg};

endmodule

FILE: rtl/core/first_fit_slot_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_slot_allocator
// First-fit slot allocator over a max tree of slot capacities.
// ----------------------------------------------------------------------------
// Requests enter on the s_ channel: s_tuser is the kind (load, place,
// clear; kind 3 clears too), s_tdata the capacity or requested size. One
// result per request leaves on the m_ channel: m_tuser is the status,
// m_tdata carries the slot and the saturating count of unplaced requests.
// One request is worked at a time; s_tready is high only while idle.
// The time from one accept to the next is set by the tree walk through the
// one-port node memory (one read per level going down, a read and a write
// per level going up); a place that fits nowhere, a clear and a load into
// a full table skip the walk.
// The result register frees the walk from the receiver: a stalled m_tready
// holds the result and delays only the final step of the next request.
// Reset empties the table and counters at once, no clearing pass; nodes
// beyond the loaded count read as minus one.
// ----------------------------------------------------------------------------
module first_fit_slot_allocator
    import ffsa_pkg::*;
#(
    parameter int SLOTS      = SLOTS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // item_value
    input  logic [IN_TUSER_W-1:0]  s_tuser,   // kind
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // slot_index, unplaced_total, zero pad
    output logic [OUT_TUSER_W-1:0] m_tuser    // status
);

    dp_cmd_t    cmd;
    dp_status_t st;

    ffsa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    ffsa_datapath #(
        .SLOTS      (SLOTS),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cmd      (cmd),
        .st       (st)
    );

endmodule

FILE: rtl/core/ffsa_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffsa_checker
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module ffsa_checker
    import ffsa_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic [IN_TDATA_W-1:0]  s_tdata,
    input logic [IN_TUSER_W-1:0]  s_tuser,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata,
    input logic [OUT_TUSER_W-1:0] m_tuser
);

    // one request in flight: ready drops right after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while another is in flight");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == ST_LOADED || m_tuser == ST_PLACED ||
                      m_tuser == ST_NOT_PLACED || m_tuser == ST_FULL ||
                      m_tuser == ST_CLEARED))
        else $error("unknown result status");

    a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == ST_NOT_PLACED || m_tuser == ST_FULL ||
                      m_tuser == ST_CLEARED)) |-> (m_tdata[9:0] == 10'd0))
        else $error("slot reported without a load or placement");

    a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == ST_CLEARED) |-> (m_tdata[41:10] == 32'd0))
        else $error("clear left the unplaced count");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

endmodule

bind first_fit_slot_allocator ffsa_checker u_ffsa_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
